// ===== design/bqm_pkg.sv =====
// ----------------------------------------------------------------------------
// bqm_pkg
// Shared types and constants for the bilinear quad mesh generator.
// ----------------------------------------------------------------------------
package bqm_pkg;

   localparam int IDX_W      = 3;
   localparam int REQ_DATA_W = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int NUM_TERMS  = 4;

   localparam logic [1:0] TERM_C1 = 2'd0;
   localparam logic [1:0] TERM_C2 = 2'd1;
   localparam logic [1:0] TERM_C3 = 2'd2;
   localparam logic [1:0] TERM_C4 = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       wgt_en;
      logic [1:0] wgt_term;
      logic       acc_init;
      logic       acc_en;
      logic [1:0] mac_term;
      logic       div_init;
      logic       div_en;
      logic       next_point;
   } dp_cmd_type;

   typedef struct packed {
      logic req_empty;
      logic last_point;
   } dp_status_type;

endpackage

// ===== design/bilinear_quad_mesh_generator_top.sv =====
// Each point runs a four-term MAC and then the bit-serial divider (one
// quotient bit per cycle), and is held on the output until it is taken;
// a zero count request skips both and gives a single empty result. One
// request is in flight at a time.
// Reset: synchronous, clears control state and zeroes the four corners.
// ----------------------------------------------------------------------------
// bilinear_quad_mesh_generator_top
// Emits the bilinear grid points of a quadrilateral held in four corner CSRs.
// ----------------------------------------------------------------------------
module bilinear_quad_mesh_generator_top #(
   parameter int MAX_DIV     = 7,
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] cols_div, [5:3] rows_div
   input  logic [bqm_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] row_index, [5:3] col_index, point_x, point_y (COORD_WIDTH each)
   output logic [((2*bqm_pkg::IDX_W+2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic                                rsp_tlast,
   // [0] empty_mesh
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bqm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [COORD_WIDTH-1:0]              csr_data
);

   localparam int RSP_W = ((2*bqm_pkg::IDX_W + 2*COORD_WIDTH + 7) / 8) * 8;

   bqm_pkg::dp_cmd_type                cmd;
   bqm_pkg::dp_status_type             status;
   logic [bqm_pkg::IDX_W-1:0]          row_index, col_index;
   logic signed [COORD_WIDTH-1:0]      point_x, point_y;

   assign csr_ready = 1'b1;

   bqm_controller #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bqm_datapath #(
      .MAX_DIV    (MAX_DIV),
      .COORD_WIDTH(COORD_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .row_index  (row_index),
      .col_index  (col_index),
      .point_x    (point_x),
      .point_y    (point_y),
      .empty_mesh (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({point_y, point_x, col_index, row_index});
   assign rsp_tlast = status.last_point;

endmodule

// ===== design/bqm_datapath.sv =====
// ----------------------------------------------------------------------------
// bqm_datapath
// Corner registers, grid counters, weight/MAC lanes for x and y and a
// radix-2 restoring divider per lane.
// ----------------------------------------------------------------------------
module bqm_datapath #(
   parameter int MAX_DIV     = 7,
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bqm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_data,
   input  logic [bqm_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  bqm_pkg::dp_cmd_type                  cmd,
   output bqm_pkg::dp_status_type               status,
   output logic [bqm_pkg::IDX_W-1:0]            row_index,
   output logic [bqm_pkg::IDX_W-1:0]            col_index,
   output logic signed [COORD_WIDTH-1:0]        point_x,
   output logic signed [COORD_WIDTH-1:0]        point_y,
   output logic                                 empty_mesh
);

   localparam int W     = COORD_WIDTH;
   localparam int DW    = $clog2(MAX_DIV * MAX_DIV + 1);
   localparam int ACC_W = W + DW + 2;
   localparam int PRD_W = W + DW + 1;
   localparam int IW    = bqm_pkg::IDX_W;

   logic signed [W-1:0]     corner_ff [2][bqm_pkg::NUM_TERMS];
   logic [IW-1:0]           n1_ff, n1_in, n2_ff, n2_in;
   logic [IW-1:0]           i_ff, i_in, j_ff, j_in;
   logic [DW-1:0]           den_ff, den_in;
   logic [DW-1:0]           wgt_ff, wgt_in;
   logic                    empty_ff, empty_in;
   logic signed [ACC_W-1:0] acc_ff [2];
   logic signed [ACC_W-1:0] acc_in [2];
   logic [DW:0]             rem_ff [2];
   logic [DW:0]             rem_in [2];
   logic [W-1:0]            quo_ff [2];
   logic [W-1:0]            quo_in [2];

   logic [IW-1:0]           cols_sat, rows_sat, fa, fb;
   logic [2*IW-1:0]         wgt_full, den_full;
   logic signed [PRD_W-1:0] prod [2];
   logic [DW+1:0]           trial [2];
   logic [DW:0]             dvsr;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < 2; l++) begin
            for (int t = 0; t < bqm_pkg::NUM_TERMS; t++) begin
               corner_ff[l][t] <= '0;
            end
         end
      end else if (csr_we && !csr_index[bqm_pkg::CSR_IDX_W-1]) begin
         corner_ff[csr_index[0]][csr_index[2:1]] <= csr_data;
      end
   end

   always_comb begin
      cols_sat = (req_tdata[IW-1:0] > IW'(MAX_DIV)) ? IW'(MAX_DIV) : req_tdata[IW-1:0];
      rows_sat = (req_tdata[2*IW-1:IW] > IW'(MAX_DIV)) ? IW'(MAX_DIV)
                                                       : req_tdata[2*IW-1:IW];
      den_full = (2*IW)'(cols_sat) * (2*IW)'(rows_sat);
      status.req_empty  = (cols_sat == '0) || (rows_sat == '0);
      status.last_point = empty_ff || ((i_ff == n1_ff) && (j_ff == n2_ff));

      fa = (cmd.wgt_term inside {bqm_pkg::TERM_C1, bqm_pkg::TERM_C4}) ? n1_ff - i_ff : i_ff;
      fb = (cmd.wgt_term inside {bqm_pkg::TERM_C1, bqm_pkg::TERM_C2}) ? n2_ff - j_ff : j_ff;
      wgt_full = (2*IW)'(fa) * (2*IW)'(fb);
      dvsr     = {den_ff, 1'b0};

      n1_in    = n1_ff;
      n2_in    = n2_ff;
      den_in   = den_ff;
      empty_in = empty_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      wgt_in   = cmd.wgt_en ? DW'(wgt_full) : wgt_ff;

      if (cmd.load) begin
         n1_in    = cols_sat;
         n2_in    = rows_sat;
         den_in   = DW'(den_full);
         empty_in = status.req_empty;
         i_in     = '0;
         j_in     = '0;
      end else if (cmd.next_point) begin
         if (i_ff == n1_ff) begin
            i_in = '0;
            j_in = j_ff + IW'(1);
         end else begin
            i_in = i_ff + IW'(1);
         end
      end

      for (int l = 0; l < 2; l++) begin
         prod[l]   = $signed({1'b0, wgt_ff}) * corner_ff[l][cmd.mac_term];
         trial[l]  = {rem_ff[l], quo_ff[l][W-1]};
         acc_in[l] = acc_ff[l];
         rem_in[l] = rem_ff[l];
         quo_in[l] = quo_ff[l];
         if (cmd.acc_init) begin
            acc_in[l] = $signed(ACC_W'(den_ff)) + $signed(ACC_W'(den_ff) << W);
         end else if (cmd.acc_en) begin
            acc_in[l] = acc_ff[l] + $signed({prod[l], 1'b0});
         end
         if (cmd.div_init) begin
            rem_in[l] = acc_ff[l][W+DW:W];
            quo_in[l] = acc_ff[l][W-1:0];
         end else if (cmd.div_en) begin
            if (trial[l] >= {1'b0, dvsr}) begin
               rem_in[l] = (DW+1)'(trial[l] - {1'b0, dvsr});
               quo_in[l] = {quo_ff[l][W-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[l][DW:0];
               quo_in[l] = {quo_ff[l][W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         n1_ff    <= '0;
         n2_ff    <= '0;
      end else begin
         empty_ff <= empty_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         n1_ff    <= n1_in;
         n2_ff    <= n2_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      wgt_ff <= wgt_in;
      for (int l = 0; l < 2; l++) begin
         acc_ff[l] <= acc_in[l];
         rem_ff[l] <= rem_in[l];
         quo_ff[l] <= quo_in[l];
      end
   end

   assign row_index  = j_ff;
   assign col_index  = i_ff;
   assign empty_mesh = empty_ff;
   assign point_x    = empty_ff ? '0 : {~quo_ff[0][W-1], quo_ff[0][W-2:0]};
   assign point_y    = empty_ff ? '0 : {~quo_ff[1][W-1], quo_ff[1][W-2:0]};

endmodule

// ===== design/bqm_controller.sv =====
// ----------------------------------------------------------------------------
// bqm_controller
// Sequencer: request accept, four-term MAC, bit-serial divide, result handoff.
// ----------------------------------------------------------------------------
module bqm_controller #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  bqm_pkg::dp_status_type status,
   output bqm_pkg::dp_cmd_type    cmd
);

   localparam int SW = $clog2(COORD_WIDTH + 1);

   bqm_pkg::state_type state_ff, state_in;
   logic [SW-1:0]      step_ff, step_in, step_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqm_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      step_m1    = step_ff - SW'(1);
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         bqm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            step_in    = '0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.req_empty ? bqm_pkg::ST_RESULT : bqm_pkg::ST_MAC;
            end
         end
         bqm_pkg::ST_MAC: begin
            cmd.wgt_en   = (step_ff < SW'(bqm_pkg::NUM_TERMS));
            cmd.wgt_term = step_ff[1:0];
            cmd.acc_init = (step_ff == '0);
            cmd.acc_en   = (step_ff != '0);
            cmd.mac_term = step_m1[1:0];
            if (step_ff == SW'(bqm_pkg::NUM_TERMS)) begin
               step_in  = '0;
               state_in = bqm_pkg::ST_DIV;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         bqm_pkg::ST_DIV: begin
            cmd.div_init = (step_ff == '0);
            cmd.div_en   = (step_ff != '0);
            if (step_ff == SW'(COORD_WIDTH)) begin
               step_in  = '0;
               state_in = bqm_pkg::ST_RESULT;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         bqm_pkg::ST_RESULT: begin
            rsp_tvalid = 1'b1;
            step_in    = '0;
            if (rsp_tready) begin
               if (status.last_point) begin
                  state_in = bqm_pkg::ST_IDLE;
               end else begin
                  cmd.next_point = 1'b1;
                  state_in       = bqm_pkg::ST_MAC;
               end
            end
         end
         default: begin
            state_in = bqm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/bqm_checker.sv =====
// ----------------------------------------------------------------------------
// bqm_checker
// Port-level checks for the mesh generator, bound to the top level.
// ----------------------------------------------------------------------------
module bqm_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((2*bqm_pkg::IDX_W+2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic                                rsp_tlast,
   input logic                                rsp_tuser
);

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("empty mesh result not marked last");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("empty mesh result carries nonzero payload");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("not idle after last result transaction");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready held after request transaction");

endmodule

bind bilinear_quad_mesh_generator_top bqm_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_bqm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bilinear quad mesh generator. Corner registers
// are loaded over the CSR channel while the block is idle; mesh requests are
// streamed in and every grid point coming back is compared field by field
// against a predictor that evaluates the bilinear blend as an exact rational
// with round-half-up. A directed table is followed by randomized phases,
// each with its own set of corners, random flow control on the streams in
// most phases and one long output hold-off to back the block up.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CW              = 32;
   localparam int MAX_DIV         = 7;
   localparam int RSP_W           = ((2*bqm_pkg::IDX_W + 2*CW + 7)/8)*8;
   localparam int GAP_MAX         = 40;
   localparam int PRESS_CYCLES    = 1500;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 51;
   localparam int MAX_ITEMS       = 470;
   localparam int DRAIN_CYCLES    = 4*(CW + 7);
   localparam int LIMIT_CYCLES    =
      4*(MAX_ITEMS*64*(CW + 7 + GAP_MAX + 2) + PRESS_CYCLES + 20000);

   localparam logic [bqm_pkg::CSR_IDX_W-1:0] REG_C1X       = 4'd0;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] REG_C1Y       = 4'd1;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] REG_C2X       = 4'd2;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] REG_C2Y       = 4'd3;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] REG_C3X       = 4'd4;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] REG_C3Y       = 4'd5;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] REG_C4X       = 4'd6;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] REG_C4Y       = 4'd7;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] IDX_SPARE_LO  = 4'd8;
   localparam logic [bqm_pkg::CSR_IDX_W-1:0] IDX_SPARE_HI  = 4'd15;

   localparam logic [CW-1:0] CMAX = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] CMIN = 32'h8000_0000;
   localparam logic [CW-1:0] CNEG1 = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      STEP_REQ,
      STEP_CSR,
      STEP_CSR_ALL
   } step_kind_type;

   typedef struct packed {
      step_kind_type                     kind;
      logic [bqm_pkg::CSR_IDX_W-1:0]     idx;
      logic [CW-1:0]                     val;
      logic [2:0]                        cols;
      logic [2:0]                        rows;
      logic                              pinned;
      logic [CW-1:0]                     pin_x;
      logic [CW-1:0]                     pin_y;
   } dir_step_type;

   typedef struct packed {
      logic [2:0]    row;
      logic [2:0]    col;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          last;
      logic          empty;
   } mesh_point_type;

   localparam int DIR_STEPS = 28;

   // pinned rows carry their expected coordinates; the rest use the predictor
   dir_step_type dir_tab [DIR_STEPS] = '{
      '{STEP_REQ,     '0,      '0,    3'd1, 3'd1, 1'b1, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd0, 3'd0, 1'b1, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd0, 3'd5, 1'b1, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd6, 3'd0, 1'b1, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd7, 3'd7, 1'b1, '0,   '0},
      '{STEP_CSR_ALL, '0,      CMAX,  3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd7, 3'd7, 1'b1, CMAX, CMAX},
      '{STEP_REQ,     '0,      '0,    3'd3, 3'd2, 1'b1, CMAX, CMAX},
      '{STEP_CSR_ALL, '0,      CMIN,  3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd7, 3'd7, 1'b1, CMIN, CMIN},
      '{STEP_REQ,     '0,      '0,    3'd1, 3'd7, 1'b1, CMIN, CMIN},
      '{STEP_CSR,     REG_C2X, CMAX,  3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_CSR,     REG_C3X, CMAX,  3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_CSR,     REG_C3Y, CMAX,  3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_CSR,     REG_C4Y, CMAX,  3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd7, 3'd7, 1'b0, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd2, 3'd5, 1'b0, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd4, 3'd3, 1'b0, '0,   '0},
      '{STEP_CSR,     IDX_SPARE_LO, '0,    3'd0, 3'd0, 1'b0, '0, '0},
      '{STEP_CSR,     IDX_SPARE_HI, CNEG1, 3'd0, 3'd0, 1'b0, '0, '0},
      '{STEP_REQ,     '0,      '0,    3'd5, 3'd6, 1'b0, '0,   '0},
      '{STEP_CSR_ALL, '0,      '0,    3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_CSR,     REG_C1X, 32'd1, 3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_CSR,     REG_C1Y, CNEG1, 3'd0, 3'd0, 1'b0, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd2, 3'd1, 1'b0, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd2, 3'd2, 1'b0, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd7, 3'd0, 1'b1, '0,   '0},
      '{STEP_REQ,     '0,      '0,    3'd1, 3'd1, 1'b0, '0,   '0}
   };

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [bqm_pkg::REQ_DATA_W-1:0]      req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [RSP_W-1:0]                    rsp_tdata;
   logic                                rsp_tlast;
   logic                                rsp_tuser;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [bqm_pkg::CSR_IDX_W-1:0]       csr_index  = '0;
   logic [CW-1:0]                       csr_data   = '0;

   logic [CW-1:0]  corner_x [4] = '{default: '0};
   logic [CW-1:0]  corner_y [4] = '{default: '0};
   mesh_point_type pending_points [$];

   bit tx_quiet = 1'b0;
   bit rx_quiet = 1'b0;
   bit press_go = 1'b0;
   bit rx_block = 1'b0;
   int rx_hold  = 0;

   int mismatch_cnt = 0;
   int point_cnt    = 0;
   int req_cnt      = 0;
   int empty_cnt    = 0;
   int reg_writes   = 0;
   int settings_cnt = 0;

   bilinear_quad_mesh_generator_top #(
      .MAX_DIV     (MAX_DIV),
      .COORD_WIDTH (CW)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 80)
         return 0;
      if (r < 97)
         return $urandom_range(1, 3);
      return $urandom_range(8, GAP_MAX);
   endfunction

   // small meshes dominate to keep the run short
   function automatic logic [2:0] pick_count();
      if ($urandom_range(0, 9) < 7)
         return 3'($urandom_range(0, 3));
      return 3'($urandom_range(0, 7));
   endfunction

   function automatic logic [CW-1:0] pick_corner(input int mode);
      int m;
      m = (mode == 3) ? $urandom_range(0, 2) : mode;
      case (m)
         0: return CW'($urandom());
         1: return CW'($urandom_range(0, 32'h20_0000)) - CW'(32'h10_0000);
         default: begin
            case ($urandom_range(0, 4))
               0: return CMIN;
               1: return CMAX;
               2: return '0;
               3: return CNEG1;
               default: return CW'(1);
            endcase
         end
      endcase
   endfunction

   // bilinear blend of one axis, exact numerator, rounded half toward +inf
   function automatic logic [CW-1:0] blend_axis(input logic [CW-1:0] c [4],
                                                input int n1, input int n2,
                                                input int i, input int j);
      longint num, den, a, b, q;
      num = longint'((n1 - i)*(n2 - j)) * longint'($signed(c[0]))
          + longint'(i*(n2 - j))        * longint'($signed(c[1]))
          + longint'(i*j)               * longint'($signed(c[2]))
          + longint'((n1 - i)*j)        * longint'($signed(c[3]));
      den = longint'(n1*n2);
      a = 2*num + den;
      b = 2*den;
      q = a / b;
      if (a < 0 && (a % b) != 0)
         q = q - 1;
      return q[CW-1:0];
   endfunction

   function automatic void expand_request(input logic [2:0] cols, input logic [2:0] rows,
                                          input bit pinned, input logic [CW-1:0] pin_x,
                                          input logic [CW-1:0] pin_y);
      int n1, n2;
      mesh_point_type p;
      n1 = (cols > MAX_DIV) ? MAX_DIV : int'(cols);
      n2 = (rows > MAX_DIV) ? MAX_DIV : int'(rows);
      req_cnt++;
      if (n1 == 0 || n2 == 0) begin
         p = '{row: '0, col: '0, x: '0, y: '0, last: 1'b1, empty: 1'b1};
         pending_points = {pending_points, p};
         empty_cnt++;
         return;
      end
      for (int j = 0; j <= n2; j++) begin
         for (int i = 0; i <= n1; i++) begin
            p.row   = 3'(j);
            p.col   = 3'(i);
            p.x     = pinned ? pin_x : blend_axis(corner_x, n1, n2, i, j);
            p.y     = pinned ? pin_y : blend_axis(corner_y, n1, n2, i, j);
            p.last  = (i == n1 && j == n2);
            p.empty = 1'b0;
            pending_points = {pending_points, p};
         end
      end
   endfunction

   task automatic put_request(input logic [2:0] cols, input logic [2:0] rows,
                              input bit pinned, input logic [CW-1:0] pin_x,
                              input logic [CW-1:0] pin_y);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(bqm_pkg::REQ_DATA_W-6){1'b0}}, rows, cols};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expand_request(cols, rows, pinned, pin_x, pin_y);
      gap = pick_gap(tx_quiet);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // corners change only with no points outstanding
   task automatic write_reg(input logic [bqm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [CW-1:0] val);
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      csr_valid  <= 1'b1;
      csr_index  <= idx;
      csr_data   <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= REG_C4Y) begin
         if (idx[0])
            corner_y[idx[2:1]] = val;
         else
            corner_x[idx[2:1]] = val;
      end
      reg_writes++;
      csr_valid <= 1'b0;
      repeat (1 + pick_gap(tx_quiet)) @(posedge clock);
   endtask

   function automatic void flag_field(input string field, input logic [CW-1:0] want,
                                      input logic [CW-1:0] got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display("mismatch on %s at point %0d: expected %h, got %h",
                  field, point_cnt, want, got);
   endfunction

   task automatic check_point();
      mesh_point_type got, want;
      got.row   = rsp_tdata[bqm_pkg::IDX_W-1:0];
      got.col   = rsp_tdata[2*bqm_pkg::IDX_W-1:bqm_pkg::IDX_W];
      got.x     = rsp_tdata[2*bqm_pkg::IDX_W +: CW];
      got.y     = rsp_tdata[2*bqm_pkg::IDX_W+CW +: CW];
      got.last  = rsp_tlast;
      got.empty = rsp_tuser;
      point_cnt++;
      if (pending_points.size() == 0) begin
         flag_field("unexpected transaction", '0, got.x);
         return;
      end
      want = pending_points.pop_front();
      if (got.row != want.row)
         flag_field("row_index", CW'(want.row), CW'(got.row));
      if (got.col != want.col)
         flag_field("col_index", CW'(want.col), CW'(got.col));
      if (got.x != want.x)
         flag_field("point_x", want.x, got.x);
      if (got.y != want.y)
         flag_field("point_y", want.y, got.y);
      if (got.last != want.last)
         flag_field("last_point", CW'(want.last), CW'(got.last));
      if (got.empty != want.empty)
         flag_field("empty_mesh", CW'(want.empty), CW'(got.empty));
   endtask

   always @(posedge clock) begin : rsp_side
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_point();
         if (rx_block) begin
            rsp_tready <= 1'b0;
         end else if (rx_hold != 0) begin
            rx_hold    <= rx_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            g = pick_gap(rx_quiet);
            if (g == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rx_hold    <= g - 1;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // long output hold-off so the block backs up into its request port
   initial begin : rx_pressure
      wait (press_go);
      @(posedge clock);
      rx_block <= 1'b1;
      repeat (PRESS_CYCLES) @(posedge clock);
      rx_block <= 1'b0;
   end

   initial begin : watchdog
      int cycle_cnt;
      for (cycle_cnt = 0; cycle_cnt < LIMIT_CYCLES; cycle_cnt++) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int s = 0; s < DIR_STEPS; s++) begin
         case (dir_tab[s].kind)
            STEP_REQ: put_request(dir_tab[s].cols, dir_tab[s].rows, dir_tab[s].pinned,
                                  dir_tab[s].pin_x, dir_tab[s].pin_y);
            STEP_CSR: write_reg(dir_tab[s].idx, dir_tab[s].val);
            default: begin
               for (r = int'(REG_C1X); r <= int'(REG_C4Y); r++)
                  write_reg(bqm_pkg::CSR_IDX_W'(r), dir_tab[s].val);
               settings_cnt++;
            end
         endcase
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_reg(bqm_pkg::CSR_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)),
                   CW'($urandom()));
         for (r = int'(REG_C1X); r <= int'(REG_C4Y); r++)
            write_reg(bqm_pkg::CSR_IDX_W'(r), pick_corner(phase % 4));
         settings_cnt++;
         tx_quiet = (phase == 3);
         rx_quiet = (phase == 3 || phase == 6);
         if (phase == 1) begin
            press_go = 1'b1;
            tx_quiet = 1'b1;
            for (int k = 0; k < 8; k++)
               put_request(pick_count(), pick_count(), 1'b0, '0, '0);
            tx_quiet = 1'b0;
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++)
            put_request(pick_count(), pick_count(), 1'b0, '0, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d mesh requests (%0d empty), %0d points checked",
               req_cnt, empty_cnt, point_cnt);
      $display("%0d register writes over %0d corner settings, %0d mismatches",
               reg_writes, settings_cnt, mismatch_cnt);
      if (mismatch_cnt == 0 && pending_points.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bqm_pkg.sv
design/bqm_datapath.sv
design/bqm_controller.sv
design/bilinear_quad_mesh_generator_top.sv
design/bqm_checker.sv
tb/sv/tb_top.sv
